/* rtl/tga_rle_pixel_decoder_defines.svh */
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TGAD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgad check failed");

// next-cycle implication, checked out of reset
`define TGAD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgad check failed");

`endif

/* rtl/tgad_pkg.sv */
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Register indexes, reset values, stream constants and the result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgad_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSED   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PIXELS = 2'd2;

    localparam logic [2:0]  PIXEL_BYTES_RESET  = 3'd4;
    localparam logic        COMPRESSED_RESET   = 1'b1;
    localparam logic [31:0] TOTAL_PIXELS_RESET = 32'd1;

    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam logic [7:0] RUN_MASK = 8'h7F;

    localparam int TGAD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  rpt;
        logic        last;
    } tgad_result_t;

endpackage

/* rtl/tga_rle_pixel_decoder.sv */
// A pixel's final byte, once accepted, passes through the queue into the output register.
// Throughput: one stream byte per cycle; header bytes and non-final pixel bytes give no result.
// The rate, set by the front end's run and pixel counter update, holds while in_stall is low.
// Reset: asynchronous, active low; registers return to pixel_bytes 4, compressed 1,
// total_pixels 1, awaiting a packet header, queue and output empty.
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Front end classifies bytes and builds pixels, queue and output stage deliver results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_rle_pixel_decoder
    import tgad_pkg::*;
#(
    parameter int QUEUE_DEPTH = TGAD_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            pixel_value,
    output logic [7:0]             repeat_count,
    output logic                   last,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic         q_full;
    logic         push;
    tgad_result_t push_data;
    logic         q_valid;
    logic         pop;
    tgad_result_t pop_data;

    tgad_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    tgad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    tgad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .last         (last)
    );

endmodule

/* rtl/tgad_front.sv */
// ----------------------------------------------------------------------------
// TGA RLE decoder front end
// Takes stream bytes, tracks packet headers and runs, assembles pixels,
// clips repeat counts to the image and pushes results into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgad_front
    import tgad_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   q_full,
    output logic                   push,
    output tgad_result_t           push_data
);

    logic [2:0]  pb_reg, pb_next;
    logic        comp_reg, comp_next;
    logic [31:0] total_reg, total_next;
    logic        expect_reg, expect_next;
    logic        repl_reg, repl_next;
    logic [7:0]  run_reg, run_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] pr_reg, pr_next;

    logic        accept;
    logic [2:0]  pb_eff;
    logic        e_exp;
    logic [7:0]  e_run;
    logic [1:0]  e_idx;
    logic [31:0] e_asm;
    logic [31:0] e_pr;
    logic [31:0] asm_new;
    logic [7:0]  rpt;
    logic [7:0]  rpt_clip;
    logic [7:0]  run_n;
    logic        exp_n;
    logic [31:0] pr_n;
    logic        cfg_hit;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        if (pb_reg == 3'd0)
        begin
            pb_eff = 3'd1;
        end
        else if (pb_reg > 3'd4)
        begin
            pb_eff = 3'd4;
        end
        else
        begin
            pb_eff = pb_reg;
        end
    end

    always_comb
    begin
        pb_next     = pb_reg;
        comp_next   = comp_reg;
        total_next  = total_reg;
        expect_next = expect_reg;
        repl_next   = repl_reg;
        run_next    = run_reg;
        idx_next    = idx_reg;
        asm_next    = asm_reg;
        pr_next     = pr_reg;
        push        = 1'b0;
        cfg_hit     = 1'b0;
        e_exp       = expect_reg;
        e_run       = run_reg;
        e_idx       = idx_reg;
        e_asm       = asm_reg;
        e_pr        = pr_reg;
        asm_new     = '0;
        rpt         = 8'd1;
        rpt_clip    = 8'd1;
        run_n       = run_reg;
        exp_n       = expect_reg;
        pr_n        = pr_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_BYTES:
                begin
                    pb_next = cfg_data[2:0];
                    cfg_hit = 1'b1;
                end
                CFG_COMPRESSED:
                begin
                    comp_next = cfg_data[0];
                    cfg_hit   = 1'b1;
                end
                CFG_TOTAL_PIXELS:
                begin
                    total_next = cfg_data[31:0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
            if (cfg_hit)
            begin
                expect_next = 1'b1;
                repl_next   = 1'b0;
                run_next    = '0;
                idx_next    = '0;
                asm_next    = '0;
                pr_next     = '0;
            end
        end
        else if (accept)
        begin
            // start a new image
            if (pr_reg == 32'd0)
            begin
                e_exp = 1'b1;
                e_run = '0;
                e_idx = '0;
                e_asm = '0;
                e_pr  = (total_reg == 32'd0) ? 32'd1 : total_reg;
            end

            if (comp_reg && e_exp)
            begin
                repl_next   = (data_byte & RUN_FLAG) != 8'd0;
                run_next    = (data_byte & RUN_MASK) + 8'd1;
                expect_next = 1'b0;
                idx_next    = '0;
                asm_next    = '0;
                pr_next     = e_pr;
            end
            else
            begin
                asm_new = e_asm | ({24'd0, data_byte} << {e_idx, 3'b000});
                if (({1'b0, e_idx} + 3'd1) < pb_eff)
                begin
                    idx_next    = e_idx + 2'd1;
                    asm_next    = asm_new;
                    expect_next = e_exp;
                    run_next    = e_run;
                    pr_next     = e_pr;
                end
                else
                begin
                    if (comp_reg)
                    begin
                        if (repl_reg)
                        begin
                            rpt   = e_run;
                            run_n = '0;
                        end
                        else
                        begin
                            rpt   = 8'd1;
                            run_n = (e_run != 8'd0) ? e_run - 8'd1 : 8'd0;
                        end
                        if (rpt == 8'd0)
                        begin
                            rpt = 8'd1;
                        end
                        exp_n = (run_n == 8'd0) ? 1'b1 : e_exp;
                    end
                    else
                    begin
                        rpt   = 8'd1;
                        run_n = e_run;
                        exp_n = e_exp;
                    end

                    rpt_clip = ({24'd0, rpt} > e_pr) ? e_pr[7:0] : rpt;
                    pr_n     = e_pr - {24'd0, rpt_clip};
                    push     = 1'b1;

                    if (pr_n == 32'd0)
                    begin
                        expect_next = 1'b1;
                        repl_next   = 1'b0;
                        run_next    = '0;
                    end
                    else
                    begin
                        expect_next = exp_n;
                        run_next    = run_n;
                    end
                    idx_next = '0;
                    asm_next = '0;
                    pr_next  = pr_n;
                end
            end
        end
    end

    always_comb
    begin
        push_data.value = asm_new;
        push_data.rpt   = rpt_clip;
        push_data.last  = (pr_n == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg     <= PIXEL_BYTES_RESET;
            comp_reg   <= COMPRESSED_RESET;
            total_reg  <= TOTAL_PIXELS_RESET;
            expect_reg <= 1'b1;
            repl_reg   <= 1'b0;
            run_reg    <= '0;
            idx_reg    <= '0;
            asm_reg    <= '0;
            pr_reg     <= '0;
        end
        else
        begin
            pb_reg     <= pb_next;
            comp_reg   <= comp_next;
            total_reg  <= total_next;
            expect_reg <= expect_next;
            repl_reg   <= repl_next;
            run_reg    <= run_next;
            idx_reg    <= idx_next;
            asm_reg    <= asm_next;
            pr_reg     <= pr_next;
        end
    end

endmodule

/* rtl/tgad_queue.sv */
// ----------------------------------------------------------------------------
// TGA RLE decoder result queue
// Short FIFO that parts the front end from the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgad_queue
    import tgad_pkg::*;
#(
    parameter int DEPTH = TGAD_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  tgad_result_t push_data,
    output logic         full,
    output logic         q_valid,
    input  logic         pop,
    output tgad_result_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    tgad_result_t     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/tgad_back.sv */
// ----------------------------------------------------------------------------
// TGA RLE decoder output stage
// Drains the queue into the output register and holds it while stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgad_back
    import tgad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  tgad_result_t pop_data,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [31:0]  pixel_value,
    output logic [7:0]   repeat_count,
    output logic         last
);

    logic         out_valid_reg, out_valid_next;
    tgad_result_t data_reg;

    assign pop            = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop ? 1'b1 : (out_valid_reg && out_stall);

    assign out_valid    = out_valid_reg;
    assign pixel_value  = data_reg.value;
    assign repeat_count = data_reg.rpt;
    assign last         = data_reg.last;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/tgad_checker.sv */
// ----------------------------------------------------------------------------
// TGA RLE decoder port checker
// Watches the top-level ports over time; bound to the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_defines.svh"

module tgad_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pixel_value,
    input logic [7:0]  repeat_count,
    input logic        last
);

    logic [40:0] out_word;

    assign out_word = {pixel_value, repeat_count, last};

    `TGAD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
    `TGAD_ASSERT_IMP(a_rpt_range, out_valid, (repeat_count != 8'd0) && (repeat_count <= 8'd128))
    `TGAD_ASSERT_IMP(a_stall_full, in_stall, out_valid)
    `TGAD_ASSERT_IMP(a_rise_src, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind tga_rle_pixel_decoder tgad_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .repeat_count (repeat_count),
    .last         (last)
);
